// File: rtl/core/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Opcodes, cell control bundle and parameter defaults.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default geometry.
  localparam int unsigned DepthDefault     = 16;
  localparam int unsigned DataWidthDefault = 32;

  // Fixed port widths of the request and result fields.
  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 5;

  // Request opcodes; the remaining codes are a no-op.
  typedef enum logic [OpcodeWidth-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DELETE     = 3'd4
  } op_e;

  // Per-cycle command broadcast to every cell. Each flag is already
  // qualified by the accept handshake, the push and pop flags also by the full and empty checks.
  typedef struct packed {
    logic push_back;
    logic push_front;
    logic pop_front;
    logic del;
  } cell_ctrl_t;

endpackage

// File: rtl/core/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell: one slot of the queue chain
// Holds one data word and moves it toward or away from the front on command.
// Also ripples the delete-match and pop-back selection along the chain.
// ----------------------------------------------------------------------------
module dq_cell import dq_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault,
  parameter int unsigned IDX        = 0
) (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]    cnt_i,
  input  logic [DATA_WIDTH-1:0]         word_i,
  input  logic [DATA_WIDTH-1:0]         left_i,
  input  logic [DATA_WIDTH-1:0]         right_i,
  input  logic                          hit_i,
  output logic                          hit_o,
  input  logic [DATA_WIDTH-1:0]         tail_i,
  output logic [DATA_WIDTH-1:0]         tail_o,
  output logic [DATA_WIDTH-1:0]         data_o
);

  localparam int unsigned CntW = $clog2(DEPTH+1);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid;
  logic                  match;
  logic                  is_tail;
  logic                  at_count;

  // Occupancy decode for this slot.
  assign valid    = CntW'(IDX) < cnt_i;
  assign at_count = cnt_i == CntW'(IDX);
  assign is_tail  = cnt_i == CntW'(IDX + 1);

  // First-match search: a hit upstream or here makes this slot close the gap.
  assign match = valid && (data_q == word_i);
  assign hit_o = hit_i | match;

  // The last valid slot contributes its word to the pop-back result.
  assign tail_o = tail_i | (data_q & {DATA_WIDTH{is_tail}});

  // Next slot contents.
  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.push_back && at_count) begin
      data_d = word_i;
    end else if (ctrl_i.push_front) begin
      data_d = (IDX == 0) ? word_i : left_i;
    end else if (ctrl_i.pop_front) begin
      data_d = right_i;
    end else if (ctrl_i.del && hit_o) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque with delete by value
// A request is taken whenever start_i is high; busy_o stays low, since no
// request keeps the queue busy and a new one can be issued on every clock.
// Its result appears on the result ports with strobe_o high in the cycle
// right after the request and for that one cycle only; the receiver cannot
// stall it. Storage is a row of DEPTH cells, slot 0 at the front, that all
// shift together for front pushes and pops, and a delete compares every slot
// in the same cycle and closes the gap behind the first match. A pop from an
// empty queue returns 0 with empty_error_o set; a push into a full queue is
// dropped with full_error_o set.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDefault,
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [OpcodeWidth-1:0] opcode_i,
  input  logic [ValueWidth-1:0]  value_in_i,
  output logic                   strobe_o,
  output logic [ValueWidth-1:0]  value_out_o,
  output logic [CountWidth-1:0]  entry_count_o,
  output logic                   empty_error_o,
  output logic                   full_error_o,
  output logic                   found_o
);

  localparam int unsigned CntW = $clog2(DEPTH+1);

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  accept;
  logic                  full, empty;
  logic [DATA_WIDTH-1:0] word;
  cell_ctrl_t            ctrl;
  logic                  pop_back;
  logic                  del_req;
  logic                  empty_err, full_err;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic                  hit_chain [DEPTH+1];
  logic [DATA_WIDTH-1:0] tail_chain [DEPTH+1];

  logic                  strobe_q;
  logic [DATA_WIDTH-1:0] value_q, value_d;
  logic                  empty_q, full_q, found_q;

  // No request keeps the queue busy.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign word   = DATA_WIDTH'(value_in_i);
  assign full   = cnt_q == CntW'(DEPTH);
  assign empty  = cnt_q == '0;

  // Opcode decode, qualified by the full and empty checks.
  always_comb begin
    ctrl      = '0;
    pop_back  = 1'b0;
    del_req   = 1'b0;
    empty_err = 1'b0;
    full_err  = 1'b0;
    if (accept) begin
      unique case (op_e'(opcode_i))
        OP_PUSH_BACK: begin
          ctrl.push_back = ~full;
          full_err       = full;
        end
        OP_POP_BACK: begin
          pop_back  = ~empty;
          empty_err = empty;
        end
        OP_PUSH_FRONT: begin
          ctrl.push_front = ~full;
          full_err        = full;
        end
        OP_POP_FRONT: begin
          ctrl.pop_front = ~empty;
          empty_err      = empty;
        end
        OP_DELETE: begin
          ctrl.del = 1'b1;
          del_req  = 1'b1;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  // Chain of storage cells.
  assign hit_chain[0]  = 1'b0;
  assign tail_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .cnt_i   (cnt_q),
      .word_i  (word),
      .left_i  (cell_data[(i == 0) ? 0 : i - 1]),
      .right_i (cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .hit_i   (hit_chain[i]),
      .hit_o   (hit_chain[i+1]),
      .tail_i  (tail_chain[i]),
      .tail_o  (tail_chain[i+1]),
      .data_o  (cell_data[i])
    );
  end

  // Occupancy update and the word taken out.
  always_comb begin
    cnt_d   = cnt_q;
    value_d = '0;
    if (ctrl.push_back || ctrl.push_front) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_back) begin
      cnt_d   = cnt_q - CntW'(1);
      value_d = tail_chain[DEPTH];
    end else if (ctrl.pop_front) begin
      cnt_d   = cnt_q - CntW'(1);
      value_d = cell_data[0];
    end else if (del_req && hit_chain[DEPTH]) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // Control state and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      strobe_q <= accept;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_d;
      empty_q <= empty_err;
      full_q  <= full_err;
      found_q <= del_req & hit_chain[DEPTH];
    end
  end

  assign strobe_o      = strobe_q;
  assign value_out_o   = ValueWidth'(value_q);
  assign entry_count_o = CountWidth'(cnt_q);
  assign empty_error_o = empty_q;
  assign full_error_o  = full_q;
  assign found_o       = found_q;

  // Occupancy never exceeds the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("occupancy beyond depth");

  // Each accepted request yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> strobe_q)
    else $error("missing result strobe");

  // A successful delete removes exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && found_q |-> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("delete did not shrink the queue by one");

  // An empty error leaves the queue empty and returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && empty_q |-> cnt_q == '0 && value_q == '0)
    else $error("empty error with entries held");

  // A dropped push leaves the queue full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && full_q |-> cnt_q == CntW'(DEPTH))
    else $error("full error on a queue with room");

endmodule
